@@ rtl/fade_presence_sequencer_defines.svh @@
// Assertion macros for the fade presence sequencer.
// Included by the top level; it has no dependencies of its own.
`ifndef FADE_PRESENCE_SEQUENCER_DEFINES_SVH
`define FADE_PRESENCE_SEQUENCER_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, reset-qualified.
`define FPS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, reset-qualified.
`define FPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FPS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define FPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/fps_pkg.sv @@
// Shared types and constants of the fade presence sequencer.
// No dependencies; the interfaces and all modules import it.
package fps_pkg;

   localparam int FRAC_BITS    = 12;
   localparam int LEVEL_BITS   = FRAC_BITS + 1;
   localparam int WAVE_BITS    = 8;
   localparam int COUNT_BITS   = 16;
   localparam int TAG_W        = 16;
   localparam int DIV_NUM_BITS = 32;
   localparam int DIV_DEN_BITS = 17;
   localparam int ADDR_BITS    = 5;

   localparam logic [LEVEL_BITS-1:0] LEVEL_ONE = LEVEL_BITS'(1 << FRAC_BITS);

   // Phase codes as they appear on the result channel.
   typedef enum logic [1:0] {
      PH_OFF    = 2'd0,
      PH_INTRO  = 2'd1,
      PH_ACTIVE = 2'd2,
      PH_OUTRO  = 2'd3
   } phase_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BDIV,
      ST_BROM,
      ST_BMUL,
      ST_EDIV,
      ST_EROM,
      ST_EMUL,
      ST_DONE
   } state_type;

   // Which ease evaluation is in progress.
   typedef enum logic [1:0] {
      PASS_RISE,
      PASS_FALL,
      PASS_OUT
   } pass_type;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      REG_LEVEL_MIN  = 3'd0,
      REG_LEVEL_MAX  = 3'd1,
      REG_INTRO_LEN  = 3'd2,
      REG_OUTRO_LEN  = 3'd3,
      REG_RISE_LEN   = 3'd4,
      REG_FALL_LEN   = 3'd5,
      REG_BREATH_PER = 3'd6
   } reg_index_type;

endpackage

@@ rtl/fps_if.sv @@
// Channel interfaces of the fade presence sequencer: frame ticks in, results out.
// Depends on fps_pkg for field widths.
interface fps_req_if import fps_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             running;
   logic             tag_valid;
   logic [TAG_W-1:0] name_tag;

   modport source (output valid, running, tag_valid, name_tag, input ready);
   modport sink   (input valid, running, tag_valid, name_tag, output ready);
endinterface

interface fps_rsp_if import fps_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            phase;
   logic [TAG_W-1:0]      held_tag;
   logic [LEVEL_BITS-1:0] border_level;
   logic [LEVEL_BITS-1:0] band_level;
   logic [LEVEL_BITS-1:0] card_level;

   modport source (output valid, phase, held_tag, border_level, band_level, card_level,
                   input ready);
   modport sink   (input valid, phase, held_tag, border_level, band_level, card_level,
                   output ready);
endinterface

@@ rtl/fps_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on fps_pkg for default widths.
module fps_div import fps_pkg::*; #(
   parameter int NUM_W = DIV_NUM_BITS,
   parameter int DEN_W = DIV_DEN_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quo
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [DEN_W:0]   rem_sh, rem_sub;
   logic             fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
      fits    = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (go) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

@@ rtl/fps_mul.sv @@
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Depends on fps_pkg for the default width.
module fps_mul import fps_pkg::*; #(
   parameter int W = LEVEL_BITS
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           go,
   input  logic [W-1:0]   a,
   input  logic [W-1:0]   b,
   output logic           done,
   output logic [2*W-1:0] prod
);
   localparam int CNT_W = $clog2(W + 1);

   logic             busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [2*W-1:0]   acc_ff, acc_in, mcand_ff, mcand_in;
   logic [W-1:0]     mplier_ff, mplier_in;

   // Add the shifted multiplicand when the low multiplier bit is set.
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[2*W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[W-1:1]};
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (go) begin
         busy_in   = 1'b1;
         cnt_in    = CNT_W'(W);
         acc_in    = '0;
         mcand_in  = (2*W)'(a);
         mplier_in = b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule

@@ rtl/fade_presence_sequencer.sv @@
// Top level of the fade presence sequencer.
// Depends on fps_pkg, fps_if, fps_div, fps_mul and the assertion macro header.
//
// Usage: each transaction on req_if is one frame tick (running flag, tag valid flag,
// name tag). For each one the block returns exactly one transaction on rsp_if with the
// phase, the held tag and three Q1.12 levels (border, band, card).
// Operation: the tick is taken, then a shared bit-serial divider and a bit-serial
// multiplier run in sequence; each division and each multiply holds the sequencer
// until it finishes. Off and active frames use two divisions and one multiply,
// outro frames four and two, intro frames up to six and three. The next tick is
// taken once the result has gone to the output register and the sequencer is back
// in idle; one tick is in work at a time.
// The sine samples are computed on the fly from a rational approximation through the
// same divider, so there is no table memory.
// The result sits in an output register; if the receiver stalls, the next tick can
// still be taken and worked on, and it waits for the register to empty at its end.
// Reset clears the phase, counters and tag and restores the register defaults.
// Registers are written over the csr_ port at byte address 4 * index.
`include "fade_presence_sequencer_defines.svh"
module fade_presence_sequencer import fps_pkg::*; #(
   parameter int DIV_NUM_W = DIV_NUM_BITS,
   parameter int DIV_DEN_W = DIV_DEN_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   fps_req_if.sink              req_if,
   fps_rsp_if.source            rsp_if,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   localparam int L = LEVEL_BITS;
   localparam int C = COUNT_BITS;

   // Configuration registers.
   logic [L-1:0] lvl_min_ff, lvl_max_ff;
   logic [C-1:0] intro_len_ff, outro_len_ff, rise_len_ff, fall_len_ff, breath_per_ff;
   logic         csr_write;
   logic [2:0]   csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_min_ff    <= L'(1024);
         lvl_max_ff    <= L'(4096);
         intro_len_ff  <= C'(90);
         outro_len_ff  <= C'(30);
         rise_len_ff   <= C'(20);
         fall_len_ff   <= C'(20);
         breath_per_ff <= C'(120);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_LEVEL_MIN:  lvl_min_ff    <= csr_pwdata[L-1:0];
            REG_LEVEL_MAX:  lvl_max_ff    <= csr_pwdata[L-1:0];
            REG_INTRO_LEN:  intro_len_ff  <= csr_pwdata[C-1:0];
            REG_OUTRO_LEN:  outro_len_ff  <= csr_pwdata[C-1:0];
            REG_RISE_LEN:   rise_len_ff   <= csr_pwdata[C-1:0];
            REG_FALL_LEN:   fall_len_ff   <= csr_pwdata[C-1:0];
            REG_BREATH_PER: breath_per_ff <= csr_pwdata[C-1:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (csr_index)
         REG_LEVEL_MIN:  csr_prdata = 32'(lvl_min_ff);
         REG_LEVEL_MAX:  csr_prdata = 32'(lvl_max_ff);
         REG_INTRO_LEN:  csr_prdata = 32'(intro_len_ff);
         REG_OUTRO_LEN:  csr_prdata = 32'(outro_len_ff);
         REG_RISE_LEN:   csr_prdata = 32'(rise_len_ff);
         REG_FALL_LEN:   csr_prdata = 32'(fall_len_ff);
         REG_BREATH_PER: csr_prdata = 32'(breath_per_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Sequencer and datapath registers.
   state_type        state_ff, state_in;
   pass_type         pass_ff, pass_in;
   phase_type        phase_ff, phase_in;
   logic [C-1:0]     cnt_ff, cnt_in, breath_ff, breath_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [L-1:0]     border_ff, border_in, card_ff, card_in, ease_ff, ease_in, u_ff, u_in;
   logic [WAVE_BITS-1:0] idx_ff, idx_in;
   logic             div_go_ff, div_go_in, mul_go_ff, mul_go_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_phase_ff, rsp_phase_in;
   logic [TAG_W-1:0] rsp_tag_ff, rsp_tag_in;
   logic [L-1:0]     rsp_border_ff, rsp_border_in, rsp_band_ff, rsp_band_in;
   logic [L-1:0]     rsp_card_ff, rsp_card_in;

   // Unit connections.
   logic [DIV_NUM_W-1:0] div_num, div_quo;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_busy, div_done, mul_done;
   logic [L-1:0]         mul_a, mul_b;
   logic [2*L-1:0]       mul_prod;

   fps_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
      .clock (clock), .reset (reset), .go (div_go_ff), .num (div_num), .den (div_den),
      .busy (div_busy), .done (div_done), .quo (div_quo)
   );

   fps_mul #(.W(L)) u_mul (
      .clock (clock), .reset (reset), .go (mul_go_ff), .a (mul_a), .b (mul_b),
      .done (mul_done), .prod (mul_prod)
   );

   // Derived values: effective divisors, clamped levels and sine sample terms.
   logic [C-1:0]     per_eff, rise_eff, fall_eff, outro_eff;
   logic [L-1:0]     lmin_c, lmax_c, diff, rom_v, ease_val, breathe_val, prod_q, u_sat;
   logic [6:0]       rom_p;
   logic [12:0]      rom_q;
   logic [16:0]      rom_d;
   logic             rom_neg;
   logic [L:0]       ease_sum, breathe_sum;
   logic [C:0]       left;
   logic [C-1:0]     left_pos;
   logic [L:0]       u_round;
   logic             req_take, out_free;

   always_comb begin
      per_eff   = (breath_per_ff == '0) ? C'(1) : breath_per_ff;
      rise_eff  = (rise_len_ff == '0) ? C'(1) : rise_len_ff;
      fall_eff  = (fall_len_ff == '0) ? C'(1) : fall_len_ff;
      outro_eff = (outro_len_ff == '0) ? C'(1) : outro_len_ff;
      lmin_c    = (lvl_min_ff > LEVEL_ONE) ? LEVEL_ONE : lvl_min_ff;
      lmax_c    = (lvl_max_ff > LEVEL_ONE) ? LEVEL_ONE : lvl_max_ff;
      diff      = (lmax_c >= lmin_c) ? lmax_c - lmin_c : lmin_c - lmax_c;
      // Sine sample: 16 q ONE / (5 h^2 - 4 q) with q = p (h - p), h = 128.
      rom_neg   = idx_ff[WAVE_BITS-1];
      rom_p     = idx_ff[WAVE_BITS-2:0];
      rom_q     = 13'(rom_p * (8'd128 - {1'b0, rom_p}));
      rom_d     = 17'd81920 - {2'b0, rom_q, 2'b0};
      rom_v     = div_quo[L-1:0];
      ease_sum    = rom_neg ? {1'b0, LEVEL_ONE} + {1'b0, rom_v}
                            : {1'b0, LEVEL_ONE} - {1'b0, rom_v};
      breathe_sum = rom_neg ? {1'b0, LEVEL_ONE} - {1'b0, rom_v}
                            : {1'b0, LEVEL_ONE} + {1'b0, rom_v};
      ease_val    = ease_sum[L:1];
      breathe_val = breathe_sum[L:1];
      prod_q      = mul_prod[FRAC_BITS+L-1:FRAC_BITS];
      u_sat       = (div_quo > DIV_NUM_W'(LEVEL_ONE)) ? LEVEL_ONE : div_quo[L-1:0];
      u_round     = {1'b0, u_sat} + (L+1)'(16);
      left        = {1'b0, intro_len_ff} - {1'b0, cnt_ff};
      left_pos    = left[C] ? '0 : left[C-1:0];
   end

   // Divider operand selection.
   always_comb begin
      div_num = '0;
      div_den = DIV_DEN_W'(1);
      case (state_ff) inside
         ST_BDIV: begin
            div_num = DIV_NUM_W'({breath_ff, {WAVE_BITS{1'b0}}}) + DIV_NUM_W'(per_eff[C-1:1]);
            div_den = DIV_DEN_W'(per_eff);
         end
         ST_BROM, ST_EROM: begin
            div_num = DIV_NUM_W'({rom_q, 16'b0}) + DIV_NUM_W'(rom_d[16:1]);
            div_den = DIV_DEN_W'(rom_d);
         end
         ST_EDIV: begin
            case (pass_ff)
               PASS_RISE: begin
                  div_num = DIV_NUM_W'({cnt_ff, {FRAC_BITS{1'b0}}});
                  div_den = DIV_DEN_W'(rise_eff);
               end
               PASS_FALL: begin
                  div_num = DIV_NUM_W'({left_pos, {FRAC_BITS{1'b0}}});
                  div_den = DIV_DEN_W'(fall_eff);
               end
               default: begin
                  div_num = DIV_NUM_W'({cnt_ff, {FRAC_BITS{1'b0}}});
                  div_den = DIV_DEN_W'(outro_eff);
               end
            endcase
         end
         default: ;
      endcase
   end

   // Multiplier operand selection.
   always_comb begin
      mul_a = diff;
      mul_b = ease_ff;
      if (state_ff == ST_EMUL) begin
         case (pass_ff)
            PASS_RISE: mul_a = border_ff;
            PASS_FALL: mul_a = card_ff;
            default: begin
               mul_a = border_ff;
               mul_b = LEVEL_ONE - ease_ff;
            end
         endcase
      end
   end

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_take     = req_if.valid & req_if.ready;
   assign out_free     = ~rsp_valid_ff | rsp_if.ready;

   // Next state and datapath updates.
   always_comb begin
      logic [C:0] br_next;
      state_in      = state_ff;
      pass_in       = pass_ff;
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      breath_in     = breath_ff;
      tag_in        = tag_ff;
      border_in     = border_ff;
      card_in       = card_ff;
      ease_in       = ease_ff;
      u_in          = u_ff;
      idx_in        = idx_ff;
      div_go_in     = 1'b0;
      mul_go_in     = 1'b0;
      rsp_valid_in  = rsp_valid_ff & ~rsp_if.ready;
      rsp_phase_in  = rsp_phase_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_border_in = rsp_border_ff;
      rsp_band_in   = rsp_band_ff;
      rsp_card_in   = rsp_card_ff;
      br_next       = {1'b0, breath_ff} + 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               // Phase transitions on the running flag, tag changes and frame counts.
               if (req_if.running) begin
                  if (phase_in == PH_OFF || phase_in == PH_OUTRO) begin
                     phase_in  = PH_INTRO;
                     cnt_in    = '0;
                     breath_in = '0;
                  end
                  if (req_if.tag_valid && req_if.name_tag != tag_ff) begin
                     tag_in = req_if.name_tag;
                     if (phase_in == PH_ACTIVE) begin
                        phase_in = PH_INTRO;
                        cnt_in   = '0;
                     end
                  end
                  if (phase_in == PH_INTRO && cnt_in >= intro_len_ff) begin
                     phase_in = PH_ACTIVE;
                     cnt_in   = '0;
                  end
               end else begin
                  if (phase_in == PH_INTRO || phase_in == PH_ACTIVE) begin
                     phase_in = PH_OUTRO;
                     cnt_in   = '0;
                  end
                  if (phase_in == PH_OUTRO && cnt_in >= outro_len_ff) begin
                     phase_in = PH_OFF;
                     cnt_in   = '0;
                  end
               end
               if (breath_in >= per_eff) begin
                  breath_in = '0;
               end
               card_in   = '0;
               state_in  = ST_BDIV;
               div_go_in = 1'b1;
            end
         end
         ST_BDIV: begin
            if (div_done) begin
               idx_in    = div_quo[WAVE_BITS-1:0];
               state_in  = ST_BROM;
               div_go_in = 1'b1;
            end
         end
         ST_BROM: begin
            if (div_done) begin
               ease_in   = breathe_val;
               state_in  = ST_BMUL;
               mul_go_in = 1'b1;
            end
         end
         ST_BMUL: begin
            if (mul_done) begin
               border_in = (lmax_c >= lmin_c) ? lmin_c + prod_q : lmin_c - prod_q;
               if (phase_ff == PH_INTRO) begin
                  pass_in   = PASS_RISE;
                  state_in  = ST_EDIV;
                  div_go_in = 1'b1;
               end else if (phase_ff == PH_OUTRO) begin
                  pass_in   = PASS_OUT;
                  state_in  = ST_EDIV;
                  div_go_in = 1'b1;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_EDIV: begin
            if (div_done) begin
               // Ease index: quarter table plus the rounded ratio times half a table.
               u_in      = u_sat;
               idx_in    = WAVE_BITS'(64) + u_round[FRAC_BITS:5];
               state_in  = ST_EROM;
               div_go_in = 1'b1;
            end
         end
         ST_EROM: begin
            if (div_done) begin
               ease_in   = ease_val;
               state_in  = ST_EMUL;
               mul_go_in = 1'b1;
            end
         end
         ST_EMUL: begin
            if (mul_done) begin
               state_in = ST_DONE;
               case (pass_ff)
                  PASS_RISE: begin
                     border_in = prod_q;
                     card_in   = (cnt_ff < rise_len_ff) ? ease_ff : LEVEL_ONE;
                     if ($signed(left) < $signed({1'b0, fall_len_ff})) begin
                        pass_in   = PASS_FALL;
                        state_in  = ST_EDIV;
                        div_go_in = 1'b1;
                     end
                  end
                  PASS_FALL: card_in   = prod_q;
                  default:   border_in = prod_q;
               endcase
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_phase_in  = phase_ff;
               rsp_tag_in    = tag_ff;
               rsp_border_in = (phase_ff == PH_OFF) ? '0 : border_ff;
               rsp_band_in   = (phase_ff == PH_OUTRO) ? LEVEL_ONE - u_ff : LEVEL_ONE;
               rsp_card_in   = card_ff;
               // Outside the off phase, advance the saturating phase counter and the wrapping breath counter.
               if (phase_ff != PH_OFF) begin
                  if (cnt_ff != '1) begin
                     cnt_in = cnt_ff + 1'b1;
                  end
                  breath_in = (br_next >= {1'b0, per_eff}) ? '0 : br_next[C-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= PASS_RISE;
         phase_ff     <= PH_OFF;
         cnt_ff       <= '0;
         breath_ff    <= '0;
         tag_ff       <= '0;
         div_go_ff    <= 1'b0;
         mul_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         breath_ff    <= breath_in;
         tag_ff       <= tag_in;
         div_go_ff    <= div_go_in;
         mul_go_ff    <= mul_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      border_ff     <= border_in;
      card_ff       <= card_in;
      ease_ff       <= ease_in;
      u_ff          <= u_in;
      idx_ff        <= idx_in;
      rsp_phase_ff  <= rsp_phase_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_border_ff <= rsp_border_in;
      rsp_band_ff   <= rsp_band_in;
      rsp_card_ff   <= rsp_card_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.phase        = rsp_phase_ff;
   assign rsp_if.held_tag     = rsp_tag_ff;
   assign rsp_if.border_level = rsp_border_ff;
   assign rsp_if.band_level   = rsp_band_ff;
   assign rsp_if.card_level   = rsp_card_ff;

   // The phase counter stays cleared while the overlay is off.
   `FPS_ASSERT_NOW(a_off_count_clear, clock, reset, phase_ff == PH_OFF, cnt_ff == '0,
                   "phase counter nonzero while off")
   // The divider is never started while a division is still running.
   `FPS_ASSERT_NOW(a_div_start_idle, clock, reset, div_go_ff, !div_busy,
                   "divider started while busy")
   // Finishing a frame with room in the output register always presents a result.
   `FPS_ASSERT_NEXT(a_done_presents, clock, reset, state_ff == ST_DONE && out_free,
                    rsp_valid_ff && state_ff == ST_IDLE, "finished frame not presented")
endmodule
